@@ hw/rtl/erpm_pkg.sv @@
// ============================================================================
// erpm_pkg
// Shared types and constants of the encoder speed estimator.
// ============================================================================
package erpm_pkg;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_REINIT = 1'b1
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [31:0] count;
        logic [31:0] tick;
        logic [31:0] now;
    } t_item;

    localparam int NUM_W = 66;
    localparam int DEN_W = 48;
    localparam int QUO_W = 32;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic             ovf;
        logic [QUO_W-1:0] quo;
    } t_div_res;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLASSIFY,
        ST_MUL,
        ST_SUM,
        ST_DIV,
        ST_EMA,
        ST_BLEND,
        ST_OUT
    } t_back_state;

    localparam logic [2:0] CFG_CPR     = 3'd0;
    localparam logic [2:0] CFG_REVERSE = 3'd1;
    localparam logic [2:0] CFG_ALPHA   = 3'd2;
    localparam logic [2:0] CFG_MAX_GAP = 3'd3;
    localparam logic [2:0] CFG_STALL   = 3'd4;

    localparam logic [15:0] CPR_RESET     = 16'd1024;
    localparam logic        REVERSE_RESET = 1'b0;
    localparam logic [16:0] ALPHA_RESET   = 17'd13107;
    localparam logic [31:0] MAX_GAP_RESET = 32'd100000;
    localparam logic [15:0] STALL_RESET   = 16'd100;

    // 60000000 * 256 = 3 * 2^32 + RPM_SCALE_LO
    localparam logic [31:0] RPM_SCALE_LO = 32'd2475098112;
    localparam logic [33:0] RPM_SCALE_HI = 34'd3;

    localparam logic [16:0] ALPHA_ONE = 17'd65536;
    localparam logic signed [50:0] EMA_ROUND = 51'sd32768;

    localparam logic signed [31:0] RPM_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] RPM_MIN = 32'sh8000_0000;

endpackage

@@ hw/rtl/erpm_fifo.sv @@
// ============================================================================
// erpm_fifo
// Front end: accepts snapshots, classifies them and queues them for the back end.
// ============================================================================
module erpm_fifo import erpm_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_kind,
    input  logic [31:0] i_encoder_count,
    input  logic [31:0] i_timer_tick_us,
    input  logic [31:0] i_host_time_ms,
    output logic        o_q_valid,
    output t_item       o_q_item,
    input  logic        i_q_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item             r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_cnt;
    logic              w_push;
    logic              w_pop;
    t_item             w_item;

    assign o_in_ready = (r_cnt != CNT_W'(DEPTH));
    assign o_q_valid  = (r_cnt != '0);
    assign o_q_item   = r_mem[r_rd_ptr];
    assign w_push     = i_in_valid && o_in_ready;
    assign w_pop      = i_q_pop && o_q_valid;

    always_comb begin
        w_item.op    = i_kind ? OP_REINIT : OP_SAMPLE;
        w_item.count = i_encoder_count;
        w_item.tick  = i_timer_tick_us;
        w_item.now   = i_host_time_ms;
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

@@ hw/rtl/erpm_div.sv @@
// ============================================================================
// erpm_div
// Serial restoring divider with overflow detection, one quotient bit per cycle.
// ============================================================================
module erpm_div import erpm_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output t_div_res         o_res
);

    localparam int CNT_W = $clog2(QUO_W);
    localparam int HI_W  = NUM_W - QUO_W;

    logic             r_busy;
    logic             r_done;
    logic             r_ovf;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [QUO_W-1:0] r_shift;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] w_num_hi;
    logic             w_ovf;
    logic [DEN_W+1:0] w_trial;
    logic             w_fits;

    assign w_num_hi = DEN_W'(i_num[NUM_W-1:QUO_W]);
    assign w_ovf    = ({{(DEN_W - HI_W){1'b0}}, i_num[NUM_W-1:QUO_W]} >= i_den);
    assign w_trial  = {1'b0, r_rem, r_shift[QUO_W-1]} - {2'b00, r_den};
    assign w_fits   = !w_trial[DEN_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= !w_ovf;
                r_done <= w_ovf;
            end else if (r_busy && (r_cnt == CNT_W'(QUO_W - 1))) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ovf   <= w_ovf;
            r_rem   <= w_num_hi;
            r_den   <= i_den;
            r_shift <= i_num[QUO_W-1:0];
            r_cnt   <= '0;
        end else if (r_busy) begin
            r_rem   <= w_fits ? w_trial[DEN_W-1:0] : {r_rem[DEN_W-2:0], r_shift[QUO_W-1]};
            r_shift <= {r_shift[QUO_W-2:0], w_fits};
            r_cnt   <= r_cnt + 1'b1;
        end
    end

    always_comb begin
        o_res.busy = r_busy;
        o_res.done = r_done;
        o_res.ovf  = r_ovf;
        o_res.quo  = r_shift;
    end

endmodule

@@ hw/rtl/erpm_back.sv @@
// ============================================================================
// erpm_back
// Back end: updates the tracking state, computes rpm and the moving average.
// ============================================================================
module erpm_back import erpm_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  t_item               i_q_item,
    output logic                o_q_pop,
    input  logic [15:0]         i_counts_per_rev,
    input  logic                i_reverse_direction,
    input  logic [16:0]         i_ema_alpha,
    input  logic [31:0]         i_max_tick_gap,
    input  logic [15:0]         i_stall_timeout_ms,
    output logic                o_div_start,
    output logic [NUM_W-1:0]    o_div_num,
    output logic [DEN_W-1:0]    o_div_den,
    input  t_div_res            i_div_res,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic signed [31:0]  o_raw_rpm,
    output logic signed [31:0]  o_filtered_rpm,
    output logic                o_armed
);

    t_back_state r_state;
    t_back_state n_state;

    t_item              r_item;
    logic [31:0]        r_prev_count;
    logic [31:0]        r_prev_tick;
    logic [31:0]        r_last_ms;
    logic signed [31:0] r_raw;
    logic signed [31:0] r_filt;
    logic               r_seed;
    logic               r_synced;
    logic [31:0]        r_mag;
    logic               r_neg;
    logic [31:0]        r_dtick;
    logic [63:0]        r_plo;
    logic [33:0]        r_m3;
    logic [DEN_W-1:0]   r_den;
    logic signed [50:0] r_prod;
    logic               r_out_valid;
    logic signed [31:0] r_out_raw;
    logic signed [31:0] r_out_filt;
    logic               r_out_armed;

    logic               w_reinit;
    logic [31:0]        w_dtick;
    logic [31:0]        w_dcount;
    logic [31:0]        w_elapsed;
    logic               w_moved;
    logic               w_stalled;
    logic               w_gap_bad;
    logic               w_measure;
    logic [15:0]        w_cpr;
    logic [16:0]        w_alpha;
    logic signed [17:0] w_alpha_s;
    logic signed [32:0] w_diff;
    logic signed [50:0] w_blend_sum;
    logic [32:0]        w_q33;
    logic signed [31:0] w_dir_rpm;
    logic signed [31:0] w_rpm;
    logic               w_out_free;
    logic               w_out_load;

    assign w_reinit  = (r_item.op == OP_REINIT);
    assign w_dtick   = r_item.tick - r_prev_tick;
    assign w_dcount  = r_item.count - r_prev_count;
    assign w_elapsed = r_item.now - r_last_ms;
    assign w_moved   = (w_dcount != '0);
    assign w_stalled = (w_elapsed > {16'h0000, i_stall_timeout_ms});
    assign w_gap_bad = (w_dtick > i_max_tick_gap);
    assign w_measure = !w_reinit && w_moved && r_synced && (w_dtick != '0) && !w_gap_bad;

    assign w_cpr     = (i_counts_per_rev == '0) ? 16'd1 : i_counts_per_rev;
    assign w_alpha   = (i_ema_alpha > ALPHA_ONE) ? ALPHA_ONE : i_ema_alpha;
    assign w_alpha_s = signed'({1'b0, w_alpha});
    assign w_diff    = 33'(r_raw) - 33'(r_filt);
    assign w_blend_sum = {{3{r_filt[31]}}, r_filt, 16'h0000} + r_prod + EMA_ROUND;

    assign w_q33 = i_div_res.ovf ? 33'h1_FFFF_FFFF : {1'b0, i_div_res.quo};

    always_comb begin
        if (r_neg) begin
            w_dir_rpm = (w_q33 >= 33'h0_8000_0000) ? RPM_MIN : signed'(32'h0 - w_q33[31:0]);
        end else begin
            w_dir_rpm = (w_q33 >= 33'h0_7FFF_FFFF) ? RPM_MAX : signed'(w_q33[31:0]);
        end
        if (i_reverse_direction) begin
            w_rpm = (w_dir_rpm == RPM_MIN) ? RPM_MAX : 32'sd0 - w_dir_rpm;
        end else begin
            w_rpm = w_dir_rpm;
        end
    end

    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    n_state = ST_CLASSIFY;
                end
            end
            ST_CLASSIFY: begin
                if (w_reinit) begin
                    n_state = ST_OUT;
                end else if (w_measure) begin
                    n_state = ST_MUL;
                end else begin
                    n_state = ST_EMA;
                end
            end
            ST_MUL:   n_state = ST_SUM;
            ST_SUM:   n_state = ST_DIV;
            ST_DIV: begin
                if (i_div_res.done) begin
                    n_state = ST_EMA;
                end
            end
            ST_EMA:   n_state = r_seed ? ST_OUT : ST_BLEND;
            ST_BLEND: n_state = ST_OUT;
            ST_OUT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop     = (r_state == ST_IDLE) && i_q_valid;
        o_div_start = (r_state == ST_SUM);
        w_out_load  = (r_state == ST_OUT) && w_out_free;
        o_div_num   = {2'b00, r_plo} + {r_m3, 32'h0000_0000};
        o_div_den   = r_den;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_prev_count <= '0;
            r_prev_tick  <= '0;
            r_last_ms    <= '0;
            r_raw        <= '0;
            r_filt       <= '0;
            r_seed       <= 1'b1;
            r_synced     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLASSIFY) begin
                if (w_reinit) begin
                    r_prev_count <= r_item.count;
                    r_prev_tick  <= r_item.tick;
                    r_last_ms    <= r_item.now;
                    r_raw        <= '0;
                    r_filt       <= '0;
                    r_seed       <= 1'b1;
                    r_synced     <= 1'b0;
                end else if (w_moved) begin
                    if (!r_synced) begin
                        r_prev_count <= r_item.count;
                        r_prev_tick  <= r_item.tick;
                        r_last_ms    <= r_item.now;
                        r_synced     <= 1'b1;
                        r_raw        <= '0;
                    end else if (w_dtick != '0) begin
                        r_prev_count <= r_item.count;
                        r_prev_tick  <= r_item.tick;
                        r_last_ms    <= r_item.now;
                        if (w_gap_bad) begin
                            r_raw <= '0;
                        end
                    end
                end else if (w_stalled) begin
                    r_raw    <= '0;
                    r_synced <= 1'b0;
                end
            end
            if ((r_state == ST_DIV) && i_div_res.done) begin
                r_raw <= w_rpm;
            end
            if ((r_state == ST_EMA) && r_seed) begin
                r_filt <= r_raw;
                r_seed <= 1'b0;
            end
            if (r_state == ST_BLEND) begin
                r_filt <= w_blend_sum[47:16];
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_item <= i_q_item;
        end
        if (r_state == ST_CLASSIFY) begin
            r_neg   <= w_dcount[31];
            r_mag   <= w_dcount[31] ? 32'h0 - w_dcount : w_dcount;
            r_dtick <= w_dtick;
        end
        if (r_state == ST_MUL) begin
            r_plo <= 64'(r_mag) * 64'(RPM_SCALE_LO);
            r_m3  <= 34'(r_mag) * RPM_SCALE_HI;
            r_den <= DEN_W'(w_cpr) * DEN_W'(r_dtick);
        end
        if ((r_state == ST_EMA) && !r_seed) begin
            r_prod <= 51'(w_alpha_s) * 51'(w_diff);
        end
        if (w_out_load) begin
            r_out_raw   <= r_raw;
            r_out_filt  <= r_filt;
            r_out_armed <= r_synced;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_raw_rpm      = r_out_raw;
    assign o_filtered_rpm = r_out_filt;
    assign o_armed        = r_out_armed;

endmodule

@@ hw/rtl/encoder_rpm_estimator_ema_core.sv @@
// ============================================================================
// encoder_rpm_estimator_ema_core
// Encoder speed estimator with exponential moving average, signed Q23.8 rpm.
// ============================================================================
// Every accepted snapshot yields exactly one result transaction. Snapshots are
// queued on input and processed one at a time: a reinitialize snapshot goes
// from classification straight to the result register, a snapshot that only
// updates tracking state or the filter passes through the filter steps, and a
// snapshot that measures speed also waits for the 32-step serial divider that forms
// dcount * 60e6 * 256 / (counts_per_rev * dtick). The result register lets the
// next snapshot start while the previous result waits to be taken. Register
// writes are accepted in every cycle and must be issued only while the block
// is idle; there is no clearing pass after reset.
module encoder_rpm_estimator_ema_core import erpm_pkg::*; #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_kind,
    input  logic signed [31:0] i_encoder_count,
    input  logic [31:0]        i_timer_tick_us,
    input  logic [31:0]        i_host_time_ms,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_raw_rpm,
    output logic signed [31:0] o_filtered_rpm,
    output logic               o_armed
);

    logic [15:0] r_counts_per_rev;
    logic        r_reverse_direction;
    logic [16:0] r_ema_alpha;
    logic [31:0] r_max_tick_gap;
    logic [15:0] r_stall_timeout_ms;

    logic             w_q_valid;
    t_item            w_q_item;
    logic             w_q_pop;
    logic             w_div_start;
    logic [NUM_W-1:0] w_div_num;
    logic [DEN_W-1:0] w_div_den;
    t_div_res         w_div_res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counts_per_rev    <= CPR_RESET;
            r_reverse_direction <= REVERSE_RESET;
            r_ema_alpha         <= ALPHA_RESET;
            r_max_tick_gap      <= MAX_GAP_RESET;
            r_stall_timeout_ms  <= STALL_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_CPR:     r_counts_per_rev    <= i_cfg_data[15:0];
                CFG_REVERSE: r_reverse_direction <= i_cfg_data[0];
                CFG_ALPHA:   r_ema_alpha         <= i_cfg_data[16:0];
                CFG_MAX_GAP: r_max_tick_gap      <= i_cfg_data;
                CFG_STALL:   r_stall_timeout_ms  <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    erpm_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_kind          (i_kind),
        .i_encoder_count (i_encoder_count),
        .i_timer_tick_us (i_timer_tick_us),
        .i_host_time_ms  (i_host_time_ms),
        .o_q_valid       (w_q_valid),
        .o_q_item        (w_q_item),
        .i_q_pop         (w_q_pop)
    );

    erpm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_res   (w_div_res)
    );

    erpm_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_q_valid           (w_q_valid),
        .i_q_item            (w_q_item),
        .o_q_pop             (w_q_pop),
        .i_counts_per_rev    (r_counts_per_rev),
        .i_reverse_direction (r_reverse_direction),
        .i_ema_alpha         (r_ema_alpha),
        .i_max_tick_gap      (r_max_tick_gap),
        .i_stall_timeout_ms  (r_stall_timeout_ms),
        .o_div_start         (w_div_start),
        .o_div_num           (w_div_num),
        .o_div_den           (w_div_den),
        .i_div_res           (w_div_res),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_raw_rpm           (o_raw_rpm),
        .o_filtered_rpm      (o_filtered_rpm),
        .o_armed             (o_armed)
    );

    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> !w_div_res.busy)
        else $error("divider started while busy");

    a_div_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_res.done |=> !w_div_res.done)
        else $error("divider done held longer than one cycle");

    a_disarmed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_armed) |-> (o_raw_rpm == 32'sd0))
        else $error("nonzero rpm reported while disarmed");

endmodule

@@ bench/erpm_speed_checker.sv @@
// ============================================================================
// erpm_speed_checker
// Watches the register, snapshot and result channels of the encoder speed
// estimator, predicts each result from its own copy of the registers and
// tracking state, and compares every result transaction field by field.
// ============================================================================
module erpm_speed_checker import erpm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic               i_kind,
    input  logic signed [31:0] i_encoder_count,
    input  logic [31:0]        i_timer_tick_us,
    input  logic [31:0]        i_host_time_ms,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic signed [31:0] i_raw_rpm,
    input  logic signed [31:0] i_filtered_rpm,
    input  logic               i_armed,
    output int                 o_fail_count,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [31:0] raw_rpm;
        logic signed [31:0] filtered_rpm;
        logic               armed;
    } t_speed;

    logic [15:0] cfg_cpr;
    logic        cfg_reverse;
    logic [16:0] cfg_alpha;
    logic [31:0] cfg_max_gap;
    logic [15:0] cfg_stall;

    logic [31:0]        last_count;
    logic [31:0]        last_tick;
    logic [31:0]        pulse_ms;
    logic signed [31:0] raw_hold;
    logic signed [31:0] filt_hold;
    logic               seed_wait;
    logic               locked;

    t_speed expected_speeds[$];
    t_speed oldest;
    int     fails = 0;

    function automatic logic signed [31:0] rpm_from_delta(input logic signed [31:0] dcount,
                                                          input logic [31:0] dtick);
        logic [15:0] cpr;
        logic        neg;
        logic [31:0] mag;
        logic [65:0] num;
        logic [47:0] den;
        logic [65:0] quo;
        logic [32:0] quo_cap;
        longint      v;
        cpr = (cfg_cpr == 16'd0) ? 16'd1 : cfg_cpr;
        neg = dcount[31];
        mag = neg ? (32'd0 - dcount) : dcount;
        num = 66'(mag) * 66'd15360000000;
        den = 48'(cpr) * 48'(dtick);
        quo = num / den;
        quo_cap = (quo >= 66'h8000_0000) ? 33'h8000_0000 : quo[32:0];
        if (neg) begin
            v = -longint'(quo_cap);
        end else begin
            v = (quo_cap >= 33'h7FFF_FFFF) ? 64'sd2147483647 : longint'(quo_cap);
        end
        if (cfg_reverse) begin
            v = (v == -64'sd2147483648) ? 64'sd2147483647 : -v;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] ema_mix(input logic signed [31:0] raw,
                                                   input logic signed [31:0] old);
        longint a;
        longint s;
        longint q;
        a = (cfg_alpha > ALPHA_ONE) ? 64'sd65536 : longint'(cfg_alpha);
        s = a * longint'(raw) + (64'sd65536 - a) * longint'(old) + 64'sd32768;
        q = s >>> 16;
        return q[31:0];
    endfunction

    function automatic t_speed predict_speed(input t_op op, input logic [31:0] count,
                                             input logic [31:0] tick, input logic [31:0] now);
        logic [31:0]        dtick;
        logic signed [31:0] dcount;
        logic [31:0]        elapsed;
        t_speed             res;
        if (op == OP_REINIT) begin
            last_count = count;
            last_tick  = tick;
            pulse_ms   = now;
            raw_hold   = '0;
            filt_hold  = '0;
            seed_wait  = 1'b1;
            locked     = 1'b0;
        end else begin
            dtick   = tick - last_tick;
            dcount  = count - last_count;
            elapsed = now - pulse_ms;
            if (dcount != 0) begin
                if (!locked) begin
                    last_count = count;
                    last_tick  = tick;
                    pulse_ms   = now;
                    locked     = 1'b1;
                    raw_hold   = '0;
                end else if (dtick != 0) begin
                    raw_hold   = (dtick > cfg_max_gap) ? 32'sd0 : rpm_from_delta(dcount, dtick);
                    last_count = count;
                    last_tick  = tick;
                    pulse_ms   = now;
                end
            end else if (elapsed > cfg_stall) begin
                raw_hold = '0;
                locked   = 1'b0;
            end
            if (seed_wait) begin
                filt_hold = raw_hold;
                seed_wait = 1'b0;
            end else begin
                filt_hold = ema_mix(raw_hold, filt_hold);
            end
        end
        res.raw_rpm      = raw_hold;
        res.filtered_rpm = filt_hold;
        res.armed        = locked;
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_cpr     = CPR_RESET;
            cfg_reverse = REVERSE_RESET;
            cfg_alpha   = ALPHA_RESET;
            cfg_max_gap = MAX_GAP_RESET;
            cfg_stall   = STALL_RESET;
            last_count  = '0;
            last_tick   = '0;
            pulse_ms    = '0;
            raw_hold    = '0;
            filt_hold   = '0;
            seed_wait   = 1'b1;
            locked      = 1'b0;
            expected_speeds.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_CPR:     cfg_cpr     = i_cfg_data[15:0];
                    CFG_REVERSE: cfg_reverse = i_cfg_data[0];
                    CFG_ALPHA:   cfg_alpha   = i_cfg_data[16:0];
                    CFG_MAX_GAP: cfg_max_gap = i_cfg_data;
                    CFG_STALL:   cfg_stall   = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_speeds.size() == 0) begin
                    $error("result transaction with no snapshot outstanding");
                    fails++;
                end else begin
                    oldest = expected_speeds.pop_front();
                    if (i_raw_rpm !== oldest.raw_rpm) begin
                        $error("raw_rpm expected %0d, got %0d", oldest.raw_rpm, i_raw_rpm);
                        fails++;
                    end
                    if (i_filtered_rpm !== oldest.filtered_rpm) begin
                        $error("filtered_rpm expected %0d, got %0d",
                               oldest.filtered_rpm, i_filtered_rpm);
                        fails++;
                    end
                    if (i_armed !== oldest.armed) begin
                        $error("armed expected %0d, got %0d", oldest.armed, i_armed);
                        fails++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_speeds.push_back(predict_speed(t_op'(i_kind), i_encoder_count,
                                                        i_timer_tick_us, i_host_time_ms));
            end
        end
        o_pending    = expected_speeds.size();
        o_fail_count = fails;
    end

endmodule

@@ bench/encoder_rpm_estimator_ema_core_tb.sv @@
// ============================================================================
// encoder_rpm_estimator_ema_core_tb
// Drives encoder snapshots and register writes into the speed estimator with
// random snapshot and result idle gaps, a long result hold-off and drain pauses,
// and lets the checker compare every result transaction with its prediction.
// ============================================================================
module encoder_rpm_estimator_ema_core_tb import erpm_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT   = 4000;
    localparam int LONG_HOLD     = 300;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS   = 50;
    localparam int TAIL_CYCLES   = 60;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_valid = 1'b0;
    logic [2:0]         cfg_index = '0;
    logic [31:0]        cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               kind = 1'b0;
    logic signed [31:0] enc_count = '0;
    logic [31:0]        tick_us = '0;
    logic [31:0]        host_ms = '0;
    logic               out_ready = 1'b0;

    logic               cfg_ready;
    logic               in_ready;
    logic               out_valid;
    logic signed [31:0] raw_rpm;
    logic signed [31:0] filtered_rpm;
    logic               armed;
    int                 fail_count;
    int                 pending;

    bit          idle_en = 1'b1;
    bit          long_hold_req = 1'b0;
    logic [31:0] cur_count = '0;
    logic [31:0] cur_tick = '0;
    logic [31:0] cur_ms = '0;
    logic [15:0] stall_setting = STALL_RESET;
    logic [31:0] gap_setting = MAX_GAP_RESET;
    int          quiet_cycles = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    encoder_rpm_estimator_ema_core i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_kind          (kind),
        .i_encoder_count (enc_count),
        .i_timer_tick_us (tick_us),
        .i_host_time_ms  (host_ms),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_raw_rpm       (raw_rpm),
        .o_filtered_rpm  (filtered_rpm),
        .o_armed         (armed)
    );

    erpm_speed_checker i_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_kind          (kind),
        .i_encoder_count (enc_count),
        .i_timer_tick_us (tick_us),
        .i_host_time_ms  (host_ms),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_raw_rpm       (raw_rpm),
        .i_filtered_rpm  (filtered_rpm),
        .i_armed         (armed),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    always @(posedge clk) begin
        if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("encoder_rpm_estimator_ema_core_tb failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : result_sink
        int gap;
        @(negedge clk);
        forever begin
            gap = idle_en ? $urandom_range(0, 10) : 0;
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
            end else if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    task automatic send_snapshot(input t_op op, input logic [31:0] count,
                                 input logic [31:0] tick, input logic [31:0] now);
        int gap;
        gap = idle_en ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        kind      <= op;
        enc_count <= count;
        tick_us   <= tick;
        host_ms   <= now;
        cur_count = count;
        cur_tick  = tick;
        cur_ms    = now;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    task automatic step_snapshot(input logic [31:0] dc, input logic [31:0] dt,
                                 input logic [31:0] dm);
        send_snapshot(OP_SAMPLE, cur_count + dc, cur_tick + dt, cur_ms + dm);
    endtask

    task automatic wait_results_done();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic program_regs(input logic [15:0] cpr, input logic rev,
                                input logic [16:0] alpha, input logic [31:0] max_gap,
                                input logic [15:0] stall);
        wait_results_done();
        write_reg(CFG_CPR, 32'(cpr));
        write_reg(CFG_REVERSE, 32'(rev));
        write_reg(CFG_ALPHA, 32'(alpha));
        write_reg(CFG_MAX_GAP, max_gap);
        write_reg(CFG_STALL, 32'(stall));
        stall_setting = stall;
        gap_setting   = max_gap;
    endtask

    task automatic random_regs();
        logic [15:0] cpr;
        logic [16:0] alpha;
        logic [31:0] max_gap;
        logic [15:0] stall;
        int          pick;
        pick = $urandom_range(0, 9);
        cpr = (pick == 0) ? 16'd1 : (pick == 1) ? 16'd65535 : 16'($urandom_range(1, 4096));
        pick = $urandom_range(0, 9);
        alpha = (pick == 0) ? 17'd0 : (pick == 1) ? ALPHA_ONE :
                (pick == 2) ? 17'($urandom_range(65537, 131071)) : 17'($urandom_range(0, 65536));
        pick = $urandom_range(0, 9);
        max_gap = (pick == 0) ? 32'd1 : (pick == 1) ? 32'hFFFF_FFFF :
                  32'($urandom_range(1000, 200000));
        pick = $urandom_range(0, 9);
        stall = (pick == 0) ? 16'd1 : (pick == 1) ? 16'd65535 : 16'($urandom_range(20, 300));
        program_regs(cpr, 1'($urandom_range(0, 1)), alpha, max_gap, stall);
    endtask

    task automatic random_snapshot();
        int          pick;
        logic [31:0] dc;
        logic [31:0] dt;
        logic [31:0] dm;
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
            send_snapshot(OP_REINIT, $urandom, $urandom, $urandom);
        end else if (pick < 80) begin
            dc = ($urandom_range(0, 9) < 2) ? 32'd0 : 32'($urandom_range(0, 600)) - 32'd300;
            pick = $urandom_range(0, 19);
            dt = (pick == 0) ? 32'd0 : (pick == 1) ? gap_setting + 32'd1 :
                 32'($urandom_range(1, 30000));
            dm = (dc == 0) ? 32'($urandom_range(0, 2 * int'(stall_setting) + 2)) :
                 32'($urandom_range(0, 20));
            step_snapshot(dc, dt, dm);
        end else begin
            send_snapshot(OP_SAMPLE, $urandom, $urandom, $urandom);
        end
    endtask

    initial begin : stimulus
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_snapshot(OP_REINIT, 32'd0, 32'd0, 32'd0);
        step_snapshot(0, 0, 50);
        step_snapshot(10, 1000, 10);
        step_snapshot(10, 1000, 10);
        step_snapshot(10, 0, 1);
        step_snapshot(-20, 2000, 5);
        step_snapshot(5, 200000, 5);
        step_snapshot(0, 0, 100);
        step_snapshot(0, 0, 1);
        step_snapshot(7, 500, 1);
        step_snapshot(32'h7FFF_FFFF, 1, 1);
        step_snapshot(32'h8000_0000, 1, 1);
        send_snapshot(OP_REINIT, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        step_snapshot(1, 1, 1);
        step_snapshot(32'hFFFF_FFFE, 1, 1);

        program_regs(16'd0, 1'b1, 17'h1FFFF, 32'hFFFF_FFFF, 16'd65535);
        step_snapshot(32'h8000_0000, 1, 1);
        step_snapshot(100, 32'hFFFF_FFFF, 1);
        step_snapshot(1, 1, 1);

        program_regs(16'd65535, 1'b0, 17'd0, 32'd1, 16'd1);
        step_snapshot(1, 1, 1);
        step_snapshot(1, 2, 1);
        step_snapshot(0, 0, 2);

        program_regs(16'd1, 1'b0, ALPHA_ONE, 32'd1, 16'd1);
        step_snapshot(1, 1, 1);
        step_snapshot(-1, 1, 1);

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            random_regs();
            idle_en = (phase != 4);
            if (phase == 2) begin
                long_hold_req = 1'b1;
            end
            repeat (PHASE_ITEMS) random_snapshot();
        end

        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("encoder_rpm_estimator_ema_core_tb passed");
        end else begin
            $display("encoder_rpm_estimator_ema_core_tb failed");
        end
        $finish;
    end

endmodule
